// ===== design/lru_replacement_state_defines.svh =====
// assertion macros shared by the replacement state rtl
// no dependencies; each macro is empty when SYNTH is defined
`ifndef LRU_REPLACEMENT_STATE_DEFINES_SVH
`define LRU_REPLACEMENT_STATE_DEFINES_SVH
`ifndef SYNTH
`define LRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRS_ASSERT(lbl, prop, msg)
`define LRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/lrs_pkg.sv =====
// package for the lru replacement state: field widths, codes and transaction types
// no dependencies
package lrs_pkg;

	localparam int DEF_SETS = 1024;
	localparam int DEF_WAYS = 16;

	localparam int CMD_W   = 2;
	localparam int SET_W   = 10;
	localparam int WAYF_W  = 4;
	localparam int VWAY_W  = 4;

	localparam int QDEPTH  = 2;
	localparam int QP_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HIT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FILL   = 2'd2;

	typedef enum logic [1:0] {
		KIND_VICTIM = 2'd0,
		KIND_NOVIC  = 2'd1,
		KIND_HIT    = 2'd2,
		KIND_FILL   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SET_W-1:0]  set_index;
		logic [WAYF_W-1:0] way;
		logic              is_writeback;
	} request_t;

	typedef struct packed {
		logic [VWAY_W-1:0] victim_way;
		logic              victim_was_invalid;
		logic              no_victim;
	} result_t;

	typedef struct packed {
		kind_t             kind;
		logic [SET_W-1:0]  set_index;
		logic [WAYF_W-1:0] way;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} queue_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_status_t;

endpackage

// ===== design/lru_replacement_state.sv =====
// True-LRU replacement state: per set, an age (0 = most recent) and a valid bit for
// every way, held as one row per set in a RAM. A transaction is taken when start is
// high and busy is low; victim requests give one result, marked by done for exactly
// one cycle, which the receiver must take then. After reset busy stays high while the
// row RAM is cleared. Each queued operation goes through the back end as a row read,
// then a modify and, for hits and fills, a write back on the single RAM port pair; done is
// registered for victim operations. The two-entry queue lets start be taken while the back
// end works. Depends on lrs_pkg, lrs_front, lrs_back and lrs_ram.
module lru_replacement_state import lrs_pkg::*; #(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int WAY_W  = $clog2(WAYS);
	localparam int ROW_W  = WAYS * (WAY_W + 1);
	localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;

	back_status_t      status;
	queue_head_t       head;
	logic              ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [SET_AW-1:0] ram_raddr;
	logic [ROW_W-1:0]  ram_rdata;

	lrs_front #(
		.SETS(SETS),
		.WAYS(WAYS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.status (status),
		.head   (head)
	);

	lrs_back #(
		.SETS(SETS),
		.WAYS(WAYS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.done     (done),
		.result   (result)
	);

	lrs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== design/lrs_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module lrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/lrs_front.sv =====
// front end: takes requests, sorts them into operations and queues those kept for the back end
// depends on lrs_pkg and lru_replacement_state_defines.svh
`include "lru_replacement_state_defines.svh"
module lrs_front import lrs_pkg::*; #(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  request_t     request,
	input  back_status_t status,
	output queue_head_t  head
);

	op_t               fifo_q [QDEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic  set_bad;
	logic  way_bad;
	logic  keep;
	kind_t kind;
	logic  push;

	always_comb begin
		set_bad = 32'(request.set_index) >= 32'(SETS);
		way_bad = 32'(request.way) >= 32'(WAYS);
		unique case (request.command)
			CMD_VICTIM: begin
				keep = 1'b1;
				kind = set_bad ? KIND_NOVIC : KIND_VICTIM;
			end
			CMD_HIT: begin
				keep = !set_bad && !way_bad && !request.is_writeback;
				kind = KIND_HIT;
			end
			CMD_FILL: begin
				keep = !set_bad && !way_bad;
				kind = KIND_FILL;
			end
			default: begin
				keep = 1'b0;
				kind = KIND_VICTIM;
			end
		endcase
	end

	assign busy = (count_q == QCNT_W'(QDEPTH)) || status.clearing;
	assign push = start && !busy && keep;

	assign head.valid = count_q != '0;
	assign head.op    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{kind: kind, set_index: request.set_index, way: request.way};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : QP_W'(wr_ptr_q + 1'b1);
			end
			if (status.pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : QP_W'(rd_ptr_q + 1'b1);
			end
			if (push && !status.pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (!push && status.pop) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

	`LRS_ASSERT_ALWAYS(a_count_bound, count_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
	`LRS_ASSERT(a_push_fills, push |=> count_q != '0, "queued operation lost")

endmodule

// ===== design/lrs_back.sv =====
// back end: clears the set rows after reset, then reads one set row per operation, rewriting it for hits and fills
// depends on lrs_pkg and lru_replacement_state_defines.svh
`include "lru_replacement_state_defines.svh"
module lrs_back import lrs_pkg::*; #(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS,
	localparam int WAY_W  = $clog2(WAYS),
	localparam int AGE_W  = WAY_W,
	localparam int ROW_W  = WAYS * (AGE_W + 1),
	localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  queue_head_t       head,
	output back_status_t      status,
	output logic              ram_we,
	output logic [SET_AW-1:0] ram_waddr,
	output logic [ROW_W-1:0]  ram_wdata,
	output logic              ram_re,
	output logic [SET_AW-1:0] ram_raddr,
	input  logic [ROW_W-1:0]  ram_rdata,
	output logic              done,
	output result_t           result
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_READ  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t            state_q;
	logic [SET_AW-1:0] clr_cnt_q;
	op_t               op_q;
	logic              done_q;
	result_t           result_q;

	logic [AGE_W-1:0] rd_age [WAYS];
	logic             rd_valid [WAYS];
	logic [ROW_W-1:0] reset_row;
	logic [ROW_W-1:0] new_row;
	logic [WAY_W-1:0] way_idx;
	logic [AGE_W-1:0] ref_age;
	logic             inv_found;
	logic [WAY_W-1:0] inv_idx;
	logic             old_found;
	logic [WAY_W-1:0] old_idx;
	logic             is_update;
	logic             is_victim;
	result_t          result_d;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			rd_age[i]   = ram_rdata[i*AGE_W +: AGE_W];
			rd_valid[i] = ram_rdata[WAYS*AGE_W + i];
			reset_row[i*AGE_W +: AGE_W] = AGE_W'(i);
			reset_row[WAYS*AGE_W + i]   = 1'b0;
		end
	end

	// promotion of the accessed way
	always_comb begin
		way_idx = WAY_W'(op_q.way);
		ref_age = rd_age[way_idx];
		for (int i = 0; i < WAYS; i++) begin
			if (way_idx == WAY_W'(i)) begin
				new_row[i*AGE_W +: AGE_W] = '0;
			end else if (rd_age[i] < ref_age) begin
				new_row[i*AGE_W +: AGE_W] = AGE_W'(rd_age[i] + 1'b1);
			end else begin
				new_row[i*AGE_W +: AGE_W] = rd_age[i];
			end
			new_row[WAYS*AGE_W + i] = rd_valid[i] ||
				(op_q.kind == KIND_FILL && way_idx == WAY_W'(i));
		end
	end

	// victim search, lowest way first
	always_comb begin
		inv_found = 1'b0;
		inv_idx   = '0;
		old_found = 1'b0;
		old_idx   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (!rd_valid[i]) begin
				inv_found = 1'b1;
				inv_idx   = WAY_W'(i);
			end
			if (rd_age[i] == AGE_W'(WAYS - 1)) begin
				old_found = 1'b1;
				old_idx   = WAY_W'(i);
			end
		end
		result_d = '{victim_way: '0, victim_was_invalid: 1'b0, no_victim: 1'b1};
		if (op_q.kind == KIND_VICTIM) begin
			if (inv_found) begin
				result_d = '{victim_way: VWAY_W'(inv_idx), victim_was_invalid: 1'b1,
					no_victim: 1'b0};
			end else if (old_found) begin
				result_d = '{victim_way: VWAY_W'(old_idx), victim_was_invalid: 1'b0,
					no_victim: 1'b0};
			end
		end
	end

	assign is_update = op_q.kind == KIND_HIT || op_q.kind == KIND_FILL;
	assign is_victim = op_q.kind == KIND_VICTIM || op_q.kind == KIND_NOVIC;

	always_comb begin
		status.clearing = state_q == ST_CLEAR;
		status.pop      = state_q == ST_READ && head.valid;
		ram_re          = status.pop;
		ram_raddr       = SET_AW'(head.op.set_index);
		ram_we          = 1'b0;
		ram_waddr       = SET_AW'(op_q.set_index);
		ram_wdata       = new_row;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = reset_row;
			end
			ST_EXEC: begin
				ram_we = is_update;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= SET_AW'(clr_cnt_q + 1'b1);
					if (clr_cnt_q == SET_AW'(SETS - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (head.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= is_victim;
					state_q <= ST_READ;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (status.pop) begin
			op_q <= head.op;
		end
		if (state_q == ST_EXEC) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`LRS_ASSERT(a_done_after_exec, done_q |-> $past(state_q == ST_EXEC), "result without operation")
	`LRS_ASSERT(a_no_write_in_read, ram_we |-> state_q != ST_READ, "row write while reading")
	`LRS_ASSERT(a_novic_zero, done_q && result_q.no_victim |-> result_q.victim_way == '0 && !result_q.victim_was_invalid, "no victim with way set")

endmodule

// ===== dv/lrs_victim_check.sv =====
// watches the request and result channels of lru_replacement_state, keeps its own
// copy of the per-set ages and valid bits, and checks every victim result in order
// depends on lrs_pkg
module lrs_victim_check import lrs_pkg::*; #(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     done,
	input  result_t  result,
	output int       errors,
	output int       outstanding,
	output int       checked,
	output int       full_set_picks
);

	localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [AGE_W-1:0] line_age [SETS][WAYS];
	logic             line_valid [SETS][WAYS];
	result_t          pending_victims [$];
	int               fail_count;
	int               result_count;
	int               oldest_count;

	function automatic result_t choose_victim(int s);
		result_t r;
		r = '{victim_way: '0, victim_was_invalid: 1'b0, no_victim: 1'b1};
		if (s >= SETS)
			return r;
		for (int i = 0; i < WAYS; i++) begin
			if (!line_valid[s][i]) begin
				r.victim_way = i[VWAY_W-1:0];
				r.victim_was_invalid = 1'b1;
				r.no_victim = 1'b0;
				return r;
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (line_age[s][i] == AGE_W'(WAYS - 1)) begin
				r.victim_way = i[VWAY_W-1:0];
				r.no_victim = 1'b0;
				return r;
			end
		end
		return r;
	endfunction

	// ages every way younger than w by one, then makes w the most recent
	task automatic touch_way(int s, int w);
		logic [AGE_W-1:0] ref_age;
		ref_age = line_age[s][w];
		for (int i = 0; i < WAYS; i++)
			if (line_age[s][i] < ref_age)
				line_age[s][i] = line_age[s][i] + 1'b1;
		line_age[s][w] = '0;
	endtask

	task automatic compare_result(result_t got);
		result_t want;
		if (pending_victims.size() == 0) begin
			$display("%0t: expected no result, got %p", $time, got);
			fail_count++;
			return;
		end
		want = pending_victims.pop_front();
		result_count++;
		if (!want.no_victim && !want.victim_was_invalid)
			oldest_count++;
		if (got.victim_way !== want.victim_way) begin
			$display("%0t: victim_way expected %0d, got %0d", $time, want.victim_way,
				got.victim_way);
			fail_count++;
		end
		if (got.victim_was_invalid !== want.victim_was_invalid) begin
			$display("%0t: victim_was_invalid expected %0b, got %0b", $time,
				want.victim_was_invalid, got.victim_was_invalid);
			fail_count++;
		end
		if (got.no_victim !== want.no_victim) begin
			$display("%0t: no_victim expected %0b, got %0b", $time, want.no_victim,
				got.no_victim);
			fail_count++;
		end
	endtask

	task automatic take_request(request_t rq);
		int s;
		int w;
		s = int'(rq.set_index);
		w = int'(rq.way);
		if (rq.command == CMD_VICTIM) begin
			pending_victims.insert(pending_victims.size(), choose_victim(s));
		end else if (rq.command == CMD_HIT || rq.command == CMD_FILL) begin
			if (s < SETS && w < WAYS && !(rq.command == CMD_HIT && rq.is_writeback)) begin
				touch_way(s, w);
				if (rq.command == CMD_FILL)
					line_valid[s][w] = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++)
				for (int w = 0; w < WAYS; w++) begin
					line_age[s][w] = AGE_W'(w);
					line_valid[s][w] = 1'b0;
				end
			pending_victims.delete();
			fail_count = 0;
			result_count = 0;
			oldest_count = 0;
		end else begin
			// results leave in order; a result is compared before the request of the same edge is taken
			if (done === 1'b1)
				compare_result(result);
			if (start === 1'b1 && busy === 1'b0)
				take_request(request);
		end
		errors <= fail_count;
		outstanding <= pending_victims.size();
		checked <= result_count;
		full_set_picks <= oldest_count;
	end

endmodule

// ===== dv/tb_lru_replacement_state.sv =====
// top of the lru_replacement_state testbench: clock, reset, directed and random
// transactions under three idle profiles, and the verdict
// depends on lrs_pkg, lru_replacement_state and lrs_victim_check
module tb_lru_replacement_state;
	import lrs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1450;
	localparam int POOL_SIZE = 6;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;
	int       errors;
	int       outstanding;
	int       checked;
	int       full_set_picks;
	int       sent;
	int       directed;
	int       set_pool [POOL_SIZE];

	lru_replacement_state u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	lrs_victim_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.done           (done),
		.result         (result),
		.errors         (errors),
		.outstanding    (outstanding),
		.checked        (checked),
		.full_set_picks (full_set_picks)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic request_t mk(logic [CMD_W-1:0] c, int s, int w, bit wb);
		request_t r;
		r.command = c;
		r.set_index = s[SET_W-1:0];
		r.way = w[WAYF_W-1:0];
		r.is_writeback = wb;
		return r;
	endfunction

	// mostly a small pool of sets so that rows fill up and ages wrap
	function automatic request_t random_request();
		int pick;
		int s;
		logic [CMD_W-1:0] c;
		pick = $urandom_range(99);
		if (pick < 38)
			c = CMD_VICTIM;
		else if (pick < 62)
			c = CMD_HIT;
		else if (pick < 95)
			c = CMD_FILL;
		else
			c = CMD_UNUSED;
		if ($urandom_range(9) == 0)
			s = $urandom_range(1023);
		else
			s = set_pool[$urandom_range(POOL_SIZE - 1)];
		return mk(c, s, $urandom_range(15), 1'($urandom_range(1)));
	endfunction

	task automatic send(request_t r);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic idle(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	task automatic random_phase(int n, int pct);
		for (int i = 0; i < POOL_SIZE; i++)
			set_pool[i] = $urandom_range(1023);
		for (int i = 0; i < n; i++) begin
			idle(pct);
			send(random_request());
		end
	endtask

	initial begin
		sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// untouched rows: way 0 is the first invalid way
		send(mk(CMD_VICTIM, 0, 9, 1'b1));
		send(mk(CMD_VICTIM, 1023, 0, 1'b0));
		// writeback fill still updates, writeback hit does nothing
		send(mk(CMD_FILL, 0, 15, 1'b1));
		send(mk(CMD_HIT, 0, 5, 1'b0));
		send(mk(CMD_HIT, 0, 15, 1'b1));
		send(mk(CMD_UNUSED, 0, 0, 1'b1));
		send(mk(CMD_VICTIM, 0, 0, 1'b0));
		// full row: the victim comes from the ages
		for (int w = 15; w >= 0; w--) begin
			idle(32);
			send(mk(CMD_FILL, 1023, w, 1'(w % 2)));
		end
		send(mk(CMD_VICTIM, 1023, 0, 1'b0));
		send(mk(CMD_HIT, 1023, 7, 1'b0));
		send(mk(CMD_VICTIM, 1023, 15, 1'b1));
		directed = sent;

		random_phase(RANDOM_ITEMS / 3, 32);
		random_phase(RANDOM_ITEMS / 3, 70);
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
		start <= 1'b0;

		repeat (12) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);

		$display("run covered %0d transactions (%0d directed) under three idle profiles",
			sent, directed);
		$display("%0d victim results checked, %0d of them chosen by age from full rows",
			checked, full_set_picks);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", outstanding);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
